### rtl/iapf_pkg.sv
// ----------------------------------------------------------------------------
// iapf_pkg
// Types, widths and constants shared by the amplitude/phase/frequency core.
// ----------------------------------------------------------------------------
package iapf_pkg;

  localparam int DATA_W     = 16;             // I/Q, magnitude and angle width
  localparam int FREQ_W     = 24;             // frequency and sample rate width
  localparam int GUARD_BITS = 8;              // fractional guard bits in CORDIC
  localparam int CW         = 27;             // CORDIC x/y datapath width
  localparam int ZW         = 32;             // angle accumulator, 2^-32 turn
  localparam int TABLE_LEN  = 24;             // entries in the arctangent table
  localparam int MB_W       = 31;             // second multiplier operand width
  localparam int PW         = CW + MB_W;      // product width
  localparam int MAG_SHIFT  = 30 + GUARD_BITS;
  localparam int FREQ_SHIFT = 16;

  localparam logic [MB_W-1:0]   INV_GAIN_Q30 = MB_W'(652032874);
  localparam logic [PW-1:0]     MAG_RND      = PW'(1) << (MAG_SHIFT - 1);
  localparam logic [ZW-1:0]     Z_HALF       = 32'h8000_0000;
  localparam logic [ZW-1:0]     ANG_RND      = 32'h0000_8000;
  localparam logic [FREQ_W-1:0] RATE_RESET   = FREQ_W'(48000);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROTATE,
    S_MAG,
    S_FREQ,
    S_EMIT
  } iapf_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  typedef struct packed {
    logic [DATA_W-1:0]        magnitude;
    logic signed [DATA_W-1:0] angle;
    logic signed [FREQ_W-1:0] freq_hz;
    logic                     ends_record;
    logic                     run_last;
  } iapf_res_t;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest
  function automatic logic [ZW-1:0] atan_turn(input logic [4:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/iapf_if.sv
// ----------------------------------------------------------------------------
// iapf_if
// Valid/ready channels for sample requests and measurement results.
// ----------------------------------------------------------------------------
interface iapf_in_if;
  import iapf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] in_phase;
  logic signed [DATA_W-1:0] quadrature;
  logic                     record_start;
  logic                     record_end;

  modport source (output valid, in_phase, quadrature, record_start, record_end,
                  input ready);
  modport sink   (input valid, in_phase, quadrature, record_start, record_end,
                  output ready);
endinterface

interface iapf_out_if;
  import iapf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [DATA_W-1:0]        magnitude;
  logic signed [DATA_W-1:0] angle;
  logic signed [FREQ_W-1:0] freq_hz;
  logic                     ends_record;
  logic                     run_last;

  modport source (output valid, magnitude, angle, freq_hz, ends_record, run_last,
                  input ready);
  modport sink   (input valid, magnitude, angle, freq_hz, ends_record, run_last,
                  output ready);
endinterface

### rtl/iapf_cordic.sv
// ----------------------------------------------------------------------------
// iapf_cordic
// Iterative CORDIC vectoring engine: one shift-add micro-rotation per cycle.
// ----------------------------------------------------------------------------
module iapf_cordic import iapf_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic signed [DATA_W-1:0] i_smp,
  input  logic signed [DATA_W-1:0] q_smp,
  output cordic_stat_t             stat,
  output logic signed [CW-1:0]     x_out,
  output logic [ZW-1:0]            z_out
);

  localparam int NSTEP = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;
  localparam int KW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(NSTEP - 1);

  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [ZW-1:0]        z_r, z_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic                 busy_r, busy_nxt;
  logic signed [CW-1:0] xl, yl, xs, ys;
  logic [ZW-1:0]        atan_k;
  logic                 last_step;

  assign last_step = busy_r && (k_r == K_LAST);
  assign atan_k    = atan_turn(5'(k_r));

  always_comb begin
    xl = CW'(i_smp) <<< GUARD_BITS;
    yl = CW'(q_smp) <<< GUARD_BITS;
    xs = x_r >>> k_r;
    ys = y_r >>> k_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    if (load) begin
      // fold the left half-plane over by a half turn
      if (xl[CW-1]) begin
        x_nxt = -xl;
        y_nxt = -yl;
        z_nxt = Z_HALF;
      end else begin
        x_nxt = xl;
        y_nxt = yl;
        z_nxt = '0;
      end
      k_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (y_r[CW-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_k;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_k;
      end
      k_nxt    = last_step ? '0 : k_r + KW'(1);
      busy_nxt = !last_step;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      k_r    <= k_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = last_step;
  assign x_out     = x_r;
  assign z_out     = z_r;

endmodule

### rtl/instantaneous_amp_phase_freq_core.sv
// ----------------------------------------------------------------------------
// instantaneous_amp_phase_freq_core
// Magnitude, binary-angle phase and instantaneous frequency of analytic
// samples, with first-sample hold per record.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  in_chan   in   valid/ready          in_phase, quadrature, record_start,
//                                      record_end
//  out_chan  out  valid/ready          magnitude, angle, freq_hz,
//                                      ends_record, run_last
//  cfg       in   cfg_wr_en (no wait)  cfg_wr_data = sample_rate
//
//  A request passes through the CORDIC step loop, then the magnitude and
//  frequency products on the shared multiplier, then the hand-over of the
//  results to the output queue, and back to idle to take the next request.
//  The two-entry output queue lets the next request in while results wait;
//  the hand-over cycle stalls only if results from the previous request are
//  still queued. Reset is synchronous and active low; it restores a sample
//  rate of 48000 and clears the held sample and the previous angle.
// ----------------------------------------------------------------------------
module instantaneous_amp_phase_freq_core import iapf_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  iapf_in_if.sink           in_chan,
  iapf_out_if.source        out_chan,
  input  logic              cfg_wr_en,
  input  logic [FREQ_W-1:0] cfg_wr_data
);

  // samples narrower than the port are sign extended from their top bit
  localparam int SAMPLE_W = (SAMPLE_BITS < DATA_W) ? SAMPLE_BITS : DATA_W;

  iapf_state_t state_r, state_nxt;

  logic [FREQ_W-1:0]        rate_r;
  logic                     start_r, end_r, zero_r;
  logic signed [DATA_W-1:0] i_smp, q_smp;
  logic                     accept;

  cordic_stat_t             cst;
  logic signed [CW-1:0]     cx;
  logic [ZW-1:0]            cz, cz_rnd;

  logic signed [CW-1:0]     mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PW-1:0]     prod_r, prod_nxt;
  logic [PW-1:0]            mag_rnd;
  logic [PW-MAG_SHIFT-1:0]  mag_full;
  logic [DATA_W-1:0]        mag_r, mag_sat;
  logic [DATA_W-1:0]        ang_w, ang_step;
  logic signed [FREQ_W-1:0] freq_w;

  // FSM outputs
  logic in_ready, cordic_load, mul_freq, cap_mag, load_q;

  // record state
  logic                     holding_r, holding_nxt;
  logic [DATA_W-1:0]        held_mag_r, held_mag_nxt;
  logic [DATA_W-1:0]        held_ang_r, held_ang_nxt;
  logic [DATA_W-1:0]        last_ang_r, last_ang_nxt;

  // output queue
  iapf_res_t                r0, r1, q0_r, q1_r;
  logic [1:0]               n_res, out_cnt_r;
  logic                     out_pop;

  assign accept = in_chan.valid && in_ready;
  assign i_smp  = DATA_W'($signed(in_chan.in_phase[SAMPLE_W-1:0]));
  assign q_smp  = DATA_W'($signed(in_chan.quadrature[SAMPLE_W-1:0]));

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
    end else if (cfg_wr_en) begin
      rate_r <= cfg_wr_data;
    end
  end

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_ROTATE;
      S_ROTATE: if (cst.done) state_nxt = S_MAG;
      S_MAG:    state_nxt = S_FREQ;
      S_FREQ:   state_nxt = S_EMIT;
      S_EMIT:   if (out_cnt_r == 2'd0) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cordic_load = 1'b0;
    mul_freq    = 1'b0;
    cap_mag     = 1'b0;
    load_q      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cordic_load = in_chan.valid;
      end
      S_FREQ: begin
        mul_freq = 1'b1;
        cap_mag  = 1'b1;
      end
      S_EMIT:  load_q = (out_cnt_r == 2'd0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_chan.ready = in_ready;

  // hold the record flags and the all-zero case of the request
  always_ff @(posedge clk) begin
    if (accept) begin
      start_r <= in_chan.record_start;
      end_r   <= in_chan.record_end;
      zero_r  <= (i_smp == '0) && (q_smp == '0);
    end
  end

  // --------------------------------------------------------------- CORDIC
  iapf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (cordic_load),
    .i_smp (i_smp),
    .q_smp (q_smp),
    .stat  (cst),
    .x_out (cx),
    .z_out (cz)
  );

  // round the accumulator half up to 16 bits; a zero sample reads angle 0
  assign cz_rnd   = cz + ANG_RND;
  assign ang_w    = zero_r ? '0 : cz_rnd[ZW-1 -: DATA_W];
  assign ang_step = ang_w - last_ang_r;

  // ------------------------------------------------------ shared multiplier
  // MAG: x * 1/K in Q30.  FREQ: wrapped phase step * sample rate.
  always_comb begin
    if (mul_freq) begin
      mul_a = CW'($signed(ang_step));
      mul_b = $signed(MB_W'(rate_r));
    end else begin
      mul_a = cx[CW-1] ? '0 : cx;
      mul_b = $signed(INV_GAIN_Q30);
    end
    prod_nxt = mul_a * mul_b;
  end

  // hold the frequency product while the hand-over waits for the queue
  always_ff @(posedge clk) begin
    if (state_r != S_EMIT) begin
      prod_r <= prod_nxt;
    end
  end

  assign mag_rnd  = prod_r + MAG_RND;
  assign mag_full = mag_rnd[PW-1:MAG_SHIFT];
  assign mag_sat  = (|mag_full[PW-MAG_SHIFT-1:DATA_W]) ? '1 : mag_full[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (cap_mag) begin
      mag_r <= zero_r ? '0 : mag_sat;
    end
  end

  // floor of product / 65536: drop the low bits of the signed product
  assign freq_w = prod_r[FREQ_SHIFT +: FREQ_W];

  // ----------------------------------------------------- record handling
  always_comb begin
    r0           = '0;
    r1           = '0;
    n_res        = 2'd0;
    holding_nxt  = holding_r;
    held_mag_nxt = held_mag_r;
    held_ang_nxt = held_ang_r;
    last_ang_nxt = ang_w;
    if (start_r) begin
      // flush a stranded first sample as a one-sample record
      if (holding_r) begin
        r0    = '{magnitude: held_mag_r, angle: held_ang_r, freq_hz: '0,
                  ends_record: 1'b1, run_last: !end_r};
        n_res = 2'd1;
      end
      if (end_r) begin
        if (holding_r) begin
          r1    = '{magnitude: mag_r, angle: ang_w, freq_hz: '0,
                    ends_record: 1'b1, run_last: 1'b1};
          n_res = 2'd2;
        end else begin
          r0    = '{magnitude: mag_r, angle: ang_w, freq_hz: '0,
                    ends_record: 1'b1, run_last: 1'b1};
          n_res = 2'd1;
        end
        holding_nxt = 1'b0;
      end else begin
        held_mag_nxt = mag_r;
        held_ang_nxt = ang_w;
        holding_nxt  = 1'b1;
      end
    end else begin
      // release the held first sample with this sample's frequency
      if (holding_r) begin
        r0    = '{magnitude: held_mag_r, angle: held_ang_r, freq_hz: freq_w,
                  ends_record: 1'b0, run_last: 1'b0};
        r1    = '{magnitude: mag_r, angle: ang_w, freq_hz: freq_w,
                  ends_record: end_r, run_last: 1'b1};
        n_res = 2'd2;
      end else begin
        r0    = '{magnitude: mag_r, angle: ang_w, freq_hz: freq_w,
                  ends_record: end_r, run_last: 1'b1};
        n_res = 2'd1;
      end
      holding_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_r  <= 1'b0;
      held_mag_r <= '0;
      held_ang_r <= '0;
      last_ang_r <= '0;
    end else if (load_q) begin
      holding_r  <= holding_nxt;
      held_mag_r <= held_mag_nxt;
      held_ang_r <= held_ang_nxt;
      last_ang_r <= last_ang_nxt;
    end
  end

  // --------------------------------------------------------- output queue
  // filled only when empty, so a load never meets a pop
  assign out_pop = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (load_q) begin
      q0_r <= r0;
      q1_r <= r1;
    end else if (out_pop) begin
      q0_r <= q1_r;
    end
    if (!rst_n) begin
      out_cnt_r <= 2'd0;
    end else if (load_q) begin
      out_cnt_r <= n_res;
    end else if (out_pop) begin
      out_cnt_r <= out_cnt_r - 2'd1;
    end
  end

  assign out_chan.valid       = (out_cnt_r != 2'd0);
  assign out_chan.magnitude   = q0_r.magnitude;
  assign out_chan.angle       = q0_r.angle;
  assign out_chan.freq_hz     = q0_r.freq_hz;
  assign out_chan.ends_record = q0_r.ends_record;
  assign out_chan.run_last    = q0_r.run_last;

  // ----------------------------------------------------------- assertions
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_chan.ready)
    else $error("request accepted while previous one in flight");

  a_done_in_rotate: assert property (@(posedge clk) disable iff (!rst_n)
    cst.done |-> (state_r == S_ROTATE))
    else $error("CORDIC finished outside the rotate phase");

  a_busy_in_rotate: assert property (@(posedge clk) disable iff (!rst_n)
    cst.busy |-> (state_r == S_ROTATE))
    else $error("CORDIC stepping outside the rotate phase");

  a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
    (load_q && start_r && !end_r) |=> holding_r)
    else $error("first sample of record not held");

  a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r != 2'd3)
    else $error("output queue overfilled");

  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    load_q |-> !out_chan.valid)
    else $error("results loaded over pending results");

endmodule
